[hw/rtl/page_translate_with_replacement_defines.svh]
`ifndef PAGE_TRANSLATE_WITH_REPLACEMENT_DEFINES_SVH
`define PAGE_TRANSLATE_WITH_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PTWR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PTWR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ptwr_pkg.sv]
`default_nettype none

package ptwr_pkg;

    localparam int NUM_PAGES  = 256;
    localparam int MAX_FRAMES = 64;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int FCNT_W     = $clog2(MAX_FRAMES + 1);
    localparam int STEP_W     = $clog2(2 * MAX_FRAMES + 1);
    localparam int SCAN_W     = $clog2(NUM_PAGES + 1);

    localparam int VA_W      = 32;
    localparam int PA_W      = 22;
    localparam int CNT_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int SHIFT_W   = 5;
    localparam int NFR_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 7;
    localparam int OUT_DW    = 96;

    localparam int SHIFT_MIN = 4;
    localparam int SHIFT_MAX = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 2'd2;

    localparam logic POLICY_CLOCK = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_FREE    = 2'd1,
        ST_EVICT   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_HIT,
        S_CLK_START,
        S_CLK_READ,
        S_CLK_REL,
        S_FIFO_SCAN,
        S_FIFO_PICK,
        S_FIFO_FRAME,
        S_FIFO_NONE,
        S_MAP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [PA_W-1:0]    offset;
        logic [SHIFT_W-1:0] shift;
        logic               invalid;
    } addr_split_t;

    // offset sits below bit 'shift', so OR is the add
    function automatic logic [PA_W-1:0] phys_addr(
        input logic [FRAME_W-1:0] frame,
        input logic [PA_W-1:0]    offset,
        input logic [SHIFT_W-1:0] shift
    );
        logic [PA_W-1:0] base;
        base = PA_W'(frame) << shift;
        return base | offset;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ptwr_addr_split.sv]
`default_nettype none

module ptwr_addr_split import ptwr_pkg::*; (
    input  wire logic [VA_W-1:0]    vaddr,
    input  wire logic [SHIFT_W-1:0] page_shift,
    output addr_split_t             split
);

    logic [SHIFT_W-1:0] sh;
    logic [VA_W-1:0]    page_full;
    logic [VA_W-1:0]    mask;

    always_comb
    begin
        priority if (page_shift < SHIFT_W'(SHIFT_MIN))
        begin
            sh = SHIFT_W'(SHIFT_MIN);
        end
        else if (page_shift > SHIFT_W'(SHIFT_MAX))
        begin
            sh = SHIFT_W'(SHIFT_MAX);
        end
        else
        begin
            sh = page_shift;
        end

        page_full = vaddr >> sh;
        mask      = (VA_W'(1) << sh) - VA_W'(1);

        split.page    = page_full[PAGE_W-1:0];
        split.invalid = |page_full[VA_W-1:PAGE_W];
        split.offset  = PA_W'(vaddr & mask);
        split.shift   = sh;
    end

endmodule

`default_nettype wire

[hw/rtl/page_translate_with_replacement.sv]
// Page translation with demand paging and FIFO or clock replacement.
// Input stream: s_tvalid/s_tready/s_tdata carry one virtual address per beat.
// Output stream: m_tvalid/m_tready/m_tdata return one result beat per input beat,
// in order. Configuration: cfg_we/cfg_addr/cfg_wdata write page_shift (0),
// frames_in_use (1) and replace_policy (2); write only while the block is idle.
// One sequencer walks each address through the tables; it takes one address at
// a time and s_tready is high only in its idle state. A clock eviction sweeps
// up to 2 * frames_in_use + 1 steps, one step per cycle, bound by the owner
// table read port; a FIFO eviction scans all NUM_PAGES page load stamps, one
// compared per cycle through the stamp table read port.
// The result sits in an output register, so the next address is taken while a
// result waits; if the receiver stalls, the following result waits in the
// sequencer and input stops. Reset clears the valid and referenced bits, the
// frame fill count, clock hand, load tick, counters and configuration
// (page_shift 12, frames_in_use 64, FIFO); no clearing pass is needed.
`default_nettype none

`include "page_translate_with_replacement_defines.svh"

module page_translate_with_replacement import ptwr_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0]    cfg_wdata,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [VA_W-1:0]      s_tdata,   // [31:0] virtual address
    // output stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] status, [23:2] physical_address, [31:24] evicted_page,
    // [63:32] hit_total, [95:64] fault_total
    output logic [OUT_DW-1:0]         m_tdata
);

    state_t state_reg, state_next;

    logic [SHIFT_W-1:0] page_shift_reg;
    logic [NFR_W-1:0]   frames_in_use_reg;
    logic               replace_policy_reg;

    addr_split_t split;

    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [PA_W-1:0]      offset_reg, offset_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic                 invalid_reg, invalid_next;
    logic [NFR_W-1:0]     nfr_reg, nfr_next;
    logic                 policy_reg, policy_next;
    status_t              status_reg, status_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [PAGE_W-1:0]    evicted_reg, evicted_next;
    logic [FRAME_W-1:0]   hand_reg, hand_next;
    logic [STEP_W-1:0]    steps_reg, steps_next;
    logic [SCAN_W-1:0]    scan_reg, scan_next;
    logic [STAMP_W-1:0]   oldest_reg, oldest_next;
    logic [PAGE_W-1:0]    victim_reg, victim_next;
    logic                 have_reg, have_next;
    logic [FCNT_W-1:0]    busy_count_reg, busy_count_next;
    logic [STAMP_W-1:0]   load_tick_reg, load_tick_next;
    logic [CNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]     fault_cnt_reg, fault_cnt_next;
    logic [NUM_PAGES-1:0] page_valid_reg, page_valid_next;
    logic [NUM_PAGES-1:0] page_ref_reg, page_ref_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_DW-1:0]    m_tdata_reg, m_tdata_next;

    // table memories
    logic [FRAME_W-1:0] page_frame_mem [NUM_PAGES];
    logic [STAMP_W-1:0] stamp_mem      [NUM_PAGES];
    logic [PAGE_W-1:0]  owner_mem      [MAX_FRAMES];

    logic [PAGE_W-1:0]  pf_raddr;
    logic [FRAME_W-1:0] pf_rdata;
    logic [PAGE_W-1:0]  stamp_raddr;
    logic [STAMP_W-1:0] stamp_rdata;
    logic [FRAME_W-1:0] owner_raddr;
    logic [PAGE_W-1:0]  owner_rdata;
    logic               map_we;

    logic [FRAME_W-1:0] hand_start;
    logic [FRAME_W-1:0] hand_adv;
    logic [NFR_W-1:0]   hand_inc;
    logic [SCAN_W-1:0]  scan_prev;
    logic [PAGE_W-1:0]  scan_idx;
    logic [PA_W-1:0]    pa_out;
    logic [PAGE_W-1:0]  evicted_out;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    ptwr_addr_split u_split (
        .vaddr      (s_tdata),
        .page_shift (page_shift_reg),
        .split      (split)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // clock hand helpers
    assign hand_start = (NFR_W'(hand_reg) >= nfr_reg) ? '0 : hand_reg;
    assign hand_inc   = NFR_W'(hand_reg) + NFR_W'(1);
    assign hand_adv   = (hand_inc == nfr_reg) ? '0 : hand_inc[FRAME_W-1:0];

    // FIFO scan: stamp data is registered, so it belongs to the previous scan index
    assign scan_prev = scan_reg - SCAN_W'(1);
    assign scan_idx  = scan_prev[PAGE_W-1:0];

    assign pa_out      = invalid_reg ? '0 : phys_addr(frame_reg, offset_reg, shift_reg);
    assign evicted_out = (status_reg == ST_EVICT) ? evicted_reg : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                priority if (invalid_reg)
                begin
                    state_next = S_DONE;
                end
                else if (page_valid_reg[page_reg])
                begin
                    state_next = S_HIT;
                end
                else if (NFR_W'(busy_count_reg) < nfr_reg)
                begin
                    state_next = S_MAP;
                end
                else if (policy_reg == POLICY_CLOCK)
                begin
                    state_next = S_CLK_START;
                end
                else
                begin
                    state_next = S_FIFO_SCAN;
                end
            end
            S_HIT:        state_next = S_DONE;
            S_CLK_START:  state_next = S_CLK_READ;
            S_CLK_READ:
            begin
                if (!page_ref_reg[owner_rdata] || steps_reg == STEP_W'({nfr_reg, 1'b0}))
                begin
                    state_next = S_CLK_REL;
                end
            end
            S_CLK_REL:    state_next = S_MAP;
            S_FIFO_SCAN:
            begin
                if (scan_reg == SCAN_W'(NUM_PAGES))
                begin
                    state_next = S_FIFO_PICK;
                end
            end
            S_FIFO_PICK:  state_next = have_reg ? S_FIFO_FRAME : S_FIFO_NONE;
            S_FIFO_FRAME: state_next = S_MAP;
            S_FIFO_NONE:  state_next = S_MAP;
            S_MAP:        state_next = S_DONE;
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath and table access
    always_comb
    begin
        page_next       = page_reg;
        offset_next     = offset_reg;
        shift_next      = shift_reg;
        invalid_next    = invalid_reg;
        nfr_next        = nfr_reg;
        policy_next     = policy_reg;
        status_next     = status_reg;
        frame_next      = frame_reg;
        evicted_next    = evicted_reg;
        hand_next       = hand_reg;
        steps_next      = steps_reg;
        scan_next       = scan_reg;
        oldest_next     = oldest_reg;
        victim_next     = victim_reg;
        have_next       = have_reg;
        busy_count_next = busy_count_reg;
        load_tick_next  = load_tick_reg;
        hit_cnt_next    = hit_cnt_reg;
        fault_cnt_next  = fault_cnt_reg;
        page_valid_next = page_valid_reg;
        page_ref_next   = page_ref_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        pf_raddr        = page_reg;
        stamp_raddr     = scan_reg[PAGE_W-1:0];
        owner_raddr     = hand_reg;
        map_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    page_next    = split.page;
                    offset_next  = split.offset;
                    shift_next   = split.shift;
                    invalid_next = split.invalid;
                    policy_next  = replace_policy_reg;
                    priority if (frames_in_use_reg == '0)
                    begin
                        nfr_next = NFR_W'(1);
                    end
                    else if (frames_in_use_reg > NFR_W'(MAX_FRAMES))
                    begin
                        nfr_next = NFR_W'(MAX_FRAMES);
                    end
                    else
                    begin
                        nfr_next = frames_in_use_reg;
                    end
                end
            end
            S_LOOKUP:
            begin
                pf_raddr = page_reg;
                priority if (invalid_reg)
                begin
                    status_next = ST_INVALID;
                end
                else if (page_valid_reg[page_reg])
                begin
                    status_next = ST_HIT;
                end
                else
                begin
                    fault_cnt_next = sat_inc(fault_cnt_reg);
                    load_tick_next = load_tick_reg + STAMP_W'(1);
                    status_next    = ST_EVICT;
                    scan_next      = '0;
                    have_next      = 1'b0;
                    if (NFR_W'(busy_count_reg) < nfr_reg)
                    begin
                        // frames fill from the bottom, so the lowest free one is the count
                        status_next = ST_FREE;
                        frame_next  = busy_count_reg[FRAME_W-1:0];
                    end
                end
            end
            S_HIT:
            begin
                frame_next              = pf_rdata;
                hit_cnt_next            = sat_inc(hit_cnt_reg);
                page_ref_next[page_reg] = 1'b1;
            end
            S_CLK_START:
            begin
                hand_next   = hand_start;
                steps_next  = '0;
                owner_raddr = hand_start;
            end
            S_CLK_READ:
            begin
                if (!page_ref_reg[owner_rdata] || steps_reg == STEP_W'({nfr_reg, 1'b0}))
                begin
                    frame_next   = hand_reg;
                    evicted_next = owner_rdata;
                    pf_raddr     = owner_rdata;
                end
                else
                begin
                    // second chance: drop the reference and advance
                    page_ref_next[owner_rdata] = 1'b0;
                    hand_next   = hand_adv;
                    steps_next  = steps_reg + STEP_W'(1);
                    owner_raddr = hand_adv;
                end
            end
            S_CLK_REL:
            begin
                if (page_valid_reg[evicted_reg] && pf_rdata == frame_reg)
                begin
                    page_valid_next[evicted_reg] = 1'b0;
                end
            end
            S_FIFO_SCAN:
            begin
                stamp_raddr = scan_reg[PAGE_W-1:0];
                if (scan_reg != '0)
                begin
                    if (page_valid_reg[scan_idx] && (!have_reg || stamp_rdata < oldest_reg))
                    begin
                        have_next   = 1'b1;
                        oldest_next = stamp_rdata;
                        victim_next = scan_idx;
                    end
                end
                scan_next = scan_reg + SCAN_W'(1);
            end
            S_FIFO_PICK:
            begin
                pf_raddr    = victim_reg;
                owner_raddr = '0;
            end
            S_FIFO_FRAME:
            begin
                frame_next                  = pf_rdata;
                evicted_next                = victim_reg;
                page_valid_next[victim_reg] = 1'b0;
            end
            S_FIFO_NONE:
            begin
                frame_next   = '0;
                evicted_next = owner_rdata;
            end
            S_MAP:
            begin
                map_we                    = 1'b1;
                page_valid_next[page_reg] = 1'b1;
                page_ref_next[page_reg]   = 1'b1;
                if (status_reg == ST_FREE)
                begin
                    busy_count_next = busy_count_reg + FCNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {fault_cnt_reg, hit_cnt_reg, evicted_out, pa_out,
                                     status_reg};
                end
            end
            default:
            begin
                map_we = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg     <= SHIFT_W'(12);
            frames_in_use_reg  <= NFR_W'(MAX_FRAMES);
            replace_policy_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PAGE_SHIFT:     page_shift_reg     <= cfg_wdata[SHIFT_W-1:0];
                CFG_FRAMES_IN_USE:  frames_in_use_reg  <= cfg_wdata[NFR_W-1:0];
                CFG_REPLACE_POLICY: replace_policy_reg <= cfg_wdata[0];
                default:
                begin
                    page_shift_reg <= page_shift_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hand_reg       <= '0;
            busy_count_reg <= '0;
            load_tick_reg  <= '0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            page_valid_reg <= '0;
            page_ref_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hand_reg       <= hand_next;
            busy_count_reg <= busy_count_next;
            load_tick_reg  <= load_tick_next;
            hit_cnt_reg    <= hit_cnt_next;
            fault_cnt_reg  <= fault_cnt_next;
            page_valid_reg <= page_valid_next;
            page_ref_reg   <= page_ref_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        page_reg    <= page_next;
        offset_reg  <= offset_next;
        shift_reg   <= shift_next;
        invalid_reg <= invalid_next;
        nfr_reg     <= nfr_next;
        policy_reg  <= policy_next;
        status_reg  <= status_next;
        frame_reg   <= frame_next;
        evicted_reg <= evicted_next;
        steps_reg   <= steps_next;
        scan_reg    <= scan_next;
        oldest_reg  <= oldest_next;
        victim_reg  <= victim_next;
        have_reg    <= have_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            page_frame_mem[page_reg] <= frame_reg;
            stamp_mem[page_reg]      <= load_tick_reg;
        end
        pf_rdata    <= page_frame_mem[pf_raddr];
        stamp_rdata <= stamp_mem[stamp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            owner_mem[frame_reg] <= page_reg;
        end
        owner_rdata <= owner_mem[owner_raddr];
    end

    `PTWR_ASSERT_SAME(a_busy_bound, 1'b1, busy_count_reg <= FCNT_W'(MAX_FRAMES), "frame fill count above frame total")
    `PTWR_ASSERT_SAME(a_free_frame, (state_reg == S_MAP) && (status_reg == ST_FREE), frame_reg == busy_count_reg[FRAME_W-1:0], "free-frame fault not on the lowest free frame")
    `PTWR_ASSERT_SAME(a_sweep_bound, state_reg == S_CLK_READ, steps_reg <= STEP_W'({nfr_reg, 1'b0}), "clock sweep ran past its bound")
    `PTWR_ASSERT_NEXT(a_hits_monotonic, 1'b1, hit_cnt_reg >= $past(hit_cnt_reg), "hit count went down")

endmodule

`default_nettype wire
